// ----- hw/rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds on every clock edge outside reset.
`define CHK_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent.
`define CHK_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check that a consequent holds in the cycle after its antecedent.
`define CHK_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/lcdseq_pkg.sv -----
package lcdseq_pkg;

    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] byte_value;
        logic [4:0] column;
        logic [1:0] row;
    } t_in;

    typedef struct packed {
        logic        rs_level;
        logic        enable_level;
        logic [3:0]  nibble;
        logic [13:0] hold_ticks;
        logic        last;
    } t_out;

    typedef enum logic [1:0] {
        HOLD_10,
        HOLD_50,
        HOLD_1000,
        HOLD_2000
    } t_hold;

    typedef enum logic [1:0] {
        SEG_START,
        SEG_NIBBLE,
        SEG_BYTE
    } t_seg;

    typedef struct packed {
        logic       is_init;
        logic       rs;
        logic [7:0] cmd_byte;
        logic       wait_on;
        t_hold      wait_hold;
    } t_job;

    typedef struct packed {
        logic [3:0] hold_stretch;
        logic [7:0] function_set_cmd;
        logic [7:0] display_control_cmd;
        logic [7:0] entry_mode_cmd;
    } t_cfg;

    localparam logic [7:0] CMD_CLEAR = 8'h01;

    function automatic logic [10:0] hold_nominal(input t_hold h);
        logic [10:0] us;
        unique case (h)
            HOLD_10:   us = 11'd10;
            HOLD_50:   us = 11'd50;
            HOLD_1000: us = 11'd1000;
            HOLD_2000: us = 11'd2000;
            default:   us = 11'd0;
        endcase
        return us;
    endfunction

endpackage

// ----- hw/rtl/lcdseq_fifo.sv -----
module lcdseq_fifo #(
    parameter type T     = logic,
    parameter int  DEPTH = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  T     i_data,
    output logic o_full,
    input  logic i_pop,
    output T     o_data,
    output logic o_empty
);
    `include "assert_macros.svh"

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    T               r_mem [DEPTH];
    logic [AW-1:0]  r_wr_ptr;
    logic [AW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic [AW-1:0]  n_wr_ptr;
    logic [AW-1:0]  n_rd_ptr;
    logic [CW-1:0]  n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);

    `CHK_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CW'(DEPTH), "fifo count overflow")
    `CHK_IMPLY(a_no_push_full, i_clk, i_rst_n, i_push, !o_full, "fifo push while full")

endmodule

// ----- hw/rtl/lcdseq_front.sv -----
module lcdseq_front #(
    parameter int COLUMNS = 20
) (
    input  lcdseq_pkg::t_in  i_item,
    output lcdseq_pkg::t_job o_job,
    output logic             o_job_valid
);
    import lcdseq_pkg::*;

    localparam logic [2:0] OP_INIT   = 3'd0;
    localparam logic [2:0] OP_CMD    = 3'd1;
    localparam logic [2:0] OP_DATA   = 3'd2;
    localparam logic [2:0] OP_CLEAR  = 3'd3;
    localparam logic [2:0] OP_CURSOR = 3'd4;

    localparam logic [7:0] CMD_SET_ADDR = 8'h80;
    localparam logic [4:0] COL_LAST     = 5'(COLUMNS - 1);

    logic [7:0] row_base;
    logic [4:0] col_sat;
    logic [7:0] cursor_cmd;

    always_comb begin
        unique case (i_item.row)
            2'd0:    row_base = 8'h00;
            2'd1:    row_base = 8'h40;
            2'd2:    row_base = 8'h14;
            2'd3:    row_base = 8'h54;
            default: row_base = 8'h00;
        endcase
        col_sat    = (int'(i_item.column) >= COLUMNS) ? COL_LAST : i_item.column;
        cursor_cmd = (CMD_SET_ADDR | row_base) + {3'b000, col_sat};
    end

    always_comb begin
        o_job           = '0;
        o_job.wait_hold = HOLD_50;
        o_job_valid     = 1'b1;
        unique case (i_item.operation)
            OP_INIT: begin
                o_job.is_init = 1'b1;
            end
            OP_CMD: begin
                o_job.cmd_byte = i_item.byte_value;
            end
            OP_DATA: begin
                o_job.rs       = 1'b1;
                o_job.cmd_byte = i_item.byte_value;
            end
            OP_CLEAR: begin
                o_job.cmd_byte  = CMD_CLEAR;
                o_job.wait_on   = 1'b1;
                o_job.wait_hold = HOLD_2000;
            end
            OP_CURSOR: begin
                o_job.cmd_byte = cursor_cmd;
                o_job.wait_on  = 1'b1;
            end
            default: begin
                o_job_valid = 1'b0;
            end
        endcase
    end

endmodule

// ----- hw/rtl/lcdseq_back.sv -----
module lcdseq_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lcdseq_pkg::t_cfg  i_cfg,
    input  lcdseq_pkg::t_job  i_job,
    input  logic              i_job_valid,
    output logic              o_job_pop,
    output lcdseq_pkg::t_out  o_step,
    output logic              o_step_valid,
    input  logic              i_step_full
);
    import lcdseq_pkg::*;
    `include "assert_macros.svh"

    localparam logic [3:0] NIB_WAKE  = 4'h3;
    localparam logic [3:0] NIB_4BIT  = 4'h2;
    localparam logic [3:0] SEG_FINAL = 4'd8;

    logic       r_busy;
    t_job       r_job;
    logic [3:0] r_seg;
    logic [2:0] r_pos;
    logic       r_rs_drv;
    logic [3:0] r_nib_drv;

    logic       n_busy;
    t_job       n_job;
    logic [3:0] n_seg;
    logic [2:0] n_pos;
    logic       n_rs_drv;
    logic [3:0] n_nib_drv;

    t_seg       seg_kind;
    logic [3:0] seg_nib;
    logic [7:0] seg_byte;
    logic       seg_rs;
    logic       seg_wait_on;
    t_hold      seg_wait_hold;
    logic       seg_last;

    logic       st_rs;
    logic       st_e;
    logic [3:0] st_nib;
    t_hold      st_hold;
    logic       seg_end;

    logic [3:0]  stretch;
    logic [14:0] ticks;
    logic        fire;
    logic        job_done;

    always_comb begin
        seg_kind      = SEG_BYTE;
        seg_nib       = NIB_WAKE;
        seg_byte      = r_job.cmd_byte;
        seg_rs        = r_job.rs;
        seg_wait_on   = r_job.wait_on;
        seg_wait_hold = r_job.wait_hold;
        seg_last      = 1'b1;
        if (r_job.is_init) begin
            seg_rs      = 1'b0;
            seg_wait_on = 1'b1;
            seg_last    = 1'b0;
            unique case (r_seg)
                4'd0: begin
                    seg_kind      = SEG_START;
                    seg_wait_hold = HOLD_1000;
                end
                4'd1, 4'd2, 4'd3: begin
                    seg_kind      = SEG_NIBBLE;
                    seg_wait_hold = HOLD_1000;
                end
                4'd4: begin
                    seg_kind      = SEG_NIBBLE;
                    seg_nib       = NIB_4BIT;
                    seg_wait_hold = HOLD_50;
                end
                4'd5: begin
                    seg_byte      = i_cfg.function_set_cmd;
                    seg_wait_hold = HOLD_50;
                end
                4'd6: begin
                    seg_byte      = i_cfg.display_control_cmd;
                    seg_wait_hold = HOLD_50;
                end
                4'd7: begin
                    seg_byte      = i_cfg.entry_mode_cmd;
                    seg_wait_hold = HOLD_50;
                end
                default: begin
                    seg_byte      = CMD_CLEAR;
                    seg_wait_hold = HOLD_2000;
                    seg_last      = 1'b1;
                end
            endcase
        end
    end

    always_comb begin
        st_rs   = r_rs_drv;
        st_e    = 1'b0;
        st_nib  = r_nib_drv;
        st_hold = seg_wait_hold;
        seg_end = 1'b0;
        unique case (seg_kind)
            SEG_START: begin
                st_rs   = 1'b0;
                st_nib  = 4'h0;
                st_hold = HOLD_1000;
                seg_end = 1'b1;
            end
            SEG_NIBBLE: begin
                unique case (r_pos)
                    3'd0: begin
                        st_e    = 1'b1;
                        st_nib  = seg_nib;
                        st_hold = HOLD_10;
                    end
                    3'd1: begin
                        st_nib  = seg_nib;
                        st_hold = HOLD_50;
                    end
                    default: begin
                        seg_end = 1'b1;
                    end
                endcase
            end
            default: begin
                unique case (r_pos)
                    3'd0: begin
                        st_rs   = seg_rs;
                        st_hold = HOLD_50;
                    end
                    3'd1: begin
                        st_e    = 1'b1;
                        st_nib  = seg_byte[7:4];
                        st_hold = HOLD_10;
                    end
                    3'd2: begin
                        st_nib  = seg_byte[7:4];
                        st_hold = HOLD_50;
                    end
                    3'd3: begin
                        st_e    = 1'b1;
                        st_nib  = seg_byte[3:0];
                        st_hold = HOLD_10;
                    end
                    3'd4: begin
                        st_nib  = seg_byte[3:0];
                        st_hold = HOLD_50;
                        seg_end = !seg_wait_on;
                    end
                    default: begin
                        seg_end = 1'b1;
                    end
                endcase
            end
        endcase
    end

    always_comb begin
        if (i_cfg.hold_stretch == 4'd0) begin
            stretch = 4'd1;
        end else if (i_cfg.hold_stretch > 4'd8) begin
            stretch = 4'd8;
        end else begin
            stretch = i_cfg.hold_stretch;
        end
        ticks = 15'(hold_nominal(st_hold)) * 15'(stretch);
    end

    assign fire     = r_busy && !i_step_full;
    assign job_done = fire && seg_end && seg_last;

    always_comb begin
        o_job_pop = i_job_valid && (!r_busy || job_done);
        n_busy    = r_busy;
        n_job     = r_job;
        n_seg     = r_seg;
        n_pos     = r_pos;
        n_rs_drv  = r_rs_drv;
        n_nib_drv = r_nib_drv;
        if (fire) begin
            n_rs_drv  = st_rs;
            n_nib_drv = st_nib;
        end
        if (o_job_pop) begin
            n_busy = 1'b1;
            n_job  = i_job;
            n_seg  = '0;
            n_pos  = '0;
        end else if (job_done) begin
            n_busy = 1'b0;
        end else if (fire) begin
            if (seg_end) begin
                n_seg = r_seg + 1'b1;
                n_pos = '0;
            end else begin
                n_pos = r_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_seg     <= '0;
            r_pos     <= '0;
            r_rs_drv  <= 1'b0;
            r_nib_drv <= '0;
        end else begin
            r_busy    <= n_busy;
            r_seg     <= n_seg;
            r_pos     <= n_pos;
            r_rs_drv  <= n_rs_drv;
            r_nib_drv <= n_nib_drv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job;
    end

    always_comb begin
        o_step.rs_level     = st_rs;
        o_step.enable_level = st_e;
        o_step.nibble       = st_nib;
        o_step.hold_ticks   = ticks[13:0];
        o_step.last         = seg_last && seg_end;
        o_step_valid        = fire;
    end

    `CHK_IMPLY(a_single_seg, i_clk, i_rst_n, r_busy && !r_job.is_init, r_seg == 4'd0, "byte job left its segment")
    `CHK_IMPLY(a_init_seg, i_clk, i_rst_n, r_busy && r_job.is_init, r_seg <= SEG_FINAL, "init ran past its final segment")
    `CHK_NEXT(a_idle_after, i_clk, i_rst_n, job_done && !i_job_valid, !r_busy, "sequencer busy after final step")

endmodule

// ----- hw/rtl/char_lcd_nibble_write_sequencer_top.sv -----
// A request passes the request queue, the sequencer's job register and the step queue before
// its first pin step reaches the result ports. The step sequencer issues one pin step per
// cycle while the step queue is not full; unknown operations are never queued.
// Requests queue ahead of the sequencer and steps queue behind it, so each side stalls alone.
// Reset (i_rst_n low at a clock edge) empties both queues, idles the sequencer, drives RS and
// D7..D4 low and loads the registers with stretch 4 and commands 0x28, 0x0C and 0x06.
module char_lcd_nibble_write_sequencer_top #(
    parameter int COLUMNS   = 20,
    parameter int JOB_DEPTH = 2,
    parameter int RES_DEPTH = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    input  lcdseq_pkg::t_in   i_item,
    output logic              full,
    output logic              empty,
    input  logic              pop,
    output lcdseq_pkg::t_out  o_result,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [7:0]        i_cfg_data
);
    import lcdseq_pkg::*;

    localparam logic [1:0] CFG_STRETCH  = 2'd0;
    localparam logic [1:0] CFG_FUNC_SET = 2'd1;
    localparam logic [1:0] CFG_DISP_CTL = 2'd2;
    localparam logic [1:0] CFG_ENTRY    = 2'd3;

    t_cfg r_cfg;
    t_cfg n_cfg;

    t_job front_job;
    logic front_valid;
    t_job queue_job;
    logic queue_empty;
    logic job_pop;
    t_out step;
    logic step_valid;
    logic res_full;
    logic in_beat;

    assign o_cfg_ready = 1'b1;
    assign in_beat     = push && !full;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_STRETCH:  n_cfg.hold_stretch        = i_cfg_data[3:0];
                CFG_FUNC_SET: n_cfg.function_set_cmd    = i_cfg_data;
                CFG_DISP_CTL: n_cfg.display_control_cmd = i_cfg_data;
                CFG_ENTRY:    n_cfg.entry_mode_cmd      = i_cfg_data;
                default:      n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hold_stretch        <= 4'd4;
            r_cfg.function_set_cmd    <= 8'h28;
            r_cfg.display_control_cmd <= 8'h0C;
            r_cfg.entry_mode_cmd      <= 8'h06;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    lcdseq_front #(
        .COLUMNS (COLUMNS)
    ) u_front (
        .i_item      (i_item),
        .o_job       (front_job),
        .o_job_valid (front_valid)
    );

    lcdseq_fifo #(
        .T     (t_job),
        .DEPTH (JOB_DEPTH)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_beat && front_valid),
        .i_data  (front_job),
        .o_full  (full),
        .i_pop   (job_pop),
        .o_data  (queue_job),
        .o_empty (queue_empty)
    );

    lcdseq_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_job        (queue_job),
        .i_job_valid  (!queue_empty),
        .o_job_pop    (job_pop),
        .o_step       (step),
        .o_step_valid (step_valid),
        .i_step_full  (res_full)
    );

    lcdseq_fifo #(
        .T     (t_out),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (step_valid),
        .i_data  (step),
        .o_full  (res_full),
        .i_pop   (pop && !empty),
        .o_data  (o_result),
        .o_empty (empty)
    );

endmodule
